// ===== design/gdd_pkg.sv =====
`timescale 1ns / 1ps

package gdd_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int COUNT_W  = 23;
    localparam int ACC_W    = COUNT_W + 1;

    localparam int MUL_A_W  = YEAR_W;
    localparam int MUL_B_W  = 13;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

    // floor(n / 100) == (n * 5243) >> 19 for every 14-bit n
    localparam logic [MUL_B_W-1:0] RECIP_100    = 13'd5243;
    localparam int                 RECIP_SHIFT  = 19;
    localparam int                 QUOT_W       = 8;
    localparam logic [MUL_B_W-1:0] CENTURY      = 13'd100;
    localparam logic [MUL_B_W-1:0] DAYS_IN_YEAR = 13'd365;

    localparam logic [YEAR_W-1:0]  YEAR_MIN = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd9999;
    localparam logic [MONTH_W-1:0] FEB      = 4'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_Y,
        ST_MUL_Q,
        ST_LEAP,
        ST_MUL_N,
        ST_ACC_365,
        ST_ACC_N4,
        ST_ACC_QN,
        ST_ACC_Q4,
        ST_ACC_MS,
        ST_ACC_D,
        ST_DIFF,
        ST_SIGN
    } gdd_state_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [9:0] month_start(input logic [MONTH_W-1:0] m);
        logic [9:0] s;
        case (m)
            4'd1:    s = 10'd0;
            4'd2:    s = 10'd31;
            4'd3:    s = 10'd59;
            4'd4:    s = 10'd90;
            4'd5:    s = 10'd120;
            4'd6:    s = 10'd151;
            4'd7:    s = 10'd181;
            4'd8:    s = 10'd212;
            4'd9:    s = 10'd243;
            4'd10:   s = 10'd273;
            4'd11:   s = 10'd304;
            4'd12:   s = 10'd334;
            default: s = 10'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== design/gdd_mult.sv =====
`timescale 1ns / 1ps

module gdd_mult
(
    input  logic                         clk,
    input  logic [gdd_pkg::MUL_A_W-1:0]  a,
    input  logic [gdd_pkg::MUL_B_W-1:0]  b,
    output logic [gdd_pkg::MUL_P_W-1:0]  p
);

    logic [gdd_pkg::MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= gdd_pkg::MUL_P_W'(a) * gdd_pkg::MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

// ===== design/gregorian_date_difference_top.sv =====
`timescale 1ns / 1ps

// channel  | handshake             | payload
// ---------+-----------------------+-----------------------------------------------
// in       | in_valid / in_ready   | first_*, second_*, count_end_day
// out      | out_valid / out_ready | day_count, bad_date
//
// A result appears after ten sequencer steps per date through the shared multiplier
// and accumulator, then two steps for the difference and sign. in_ready is high only
// while the sequencer is idle, so a new item is taken only once the previous one has
// left the sign step.
// The result sits in an output register; the last step waits there if the
// previous item is still not taken. rst_n clears the sequencer and out_valid.

module gregorian_date_difference_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [gdd_pkg::DAY_W-1:0]           first_day,
    input  logic [gdd_pkg::MONTH_W-1:0]         first_month,
    input  logic [gdd_pkg::YEAR_W-1:0]          first_year,
    input  logic [gdd_pkg::DAY_W-1:0]           second_day,
    input  logic [gdd_pkg::MONTH_W-1:0]         second_month,
    input  logic [gdd_pkg::YEAR_W-1:0]          second_year,
    input  logic                                count_end_day,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [gdd_pkg::COUNT_W-1:0]  day_count,
    output logic                                bad_date
);

    gdd_pkg::gdd_state_t state_reg, state_next;

    logic [gdd_pkg::DAY_W-1:0]   d1_reg, d2_reg;
    logic [gdd_pkg::MONTH_W-1:0] m1_reg, m2_reg;
    logic [gdd_pkg::YEAR_W-1:0]  y1_reg, y2_reg;
    logic                        inc_reg;
    logic                        sel_reg, sel_next;
    logic                        ok_reg, ok_next;
    logic                        leap_reg, leap_next;
    logic [gdd_pkg::QUOT_W-1:0]  qy_reg, qy_next;
    logic [gdd_pkg::QUOT_W-1:0]  qn_reg, qn_next;
    logic signed [gdd_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [gdd_pkg::COUNT_W-1:0]        a_reg, a_next;
    logic                               out_valid_reg, out_valid_next;
    logic signed [gdd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                               bad_reg, bad_next;

    logic [gdd_pkg::DAY_W-1:0]   cur_d;
    logic [gdd_pkg::MONTH_W-1:0] cur_m;
    logic [gdd_pkg::YEAR_W-1:0]  cur_y;
    logic [gdd_pkg::YEAR_W-1:0]  cur_n;

    logic [gdd_pkg::MUL_A_W-1:0] mul_a;
    logic [gdd_pkg::MUL_B_W-1:0] mul_b;
    logic [gdd_pkg::MUL_P_W-1:0] prod;
    logic [gdd_pkg::QUOT_W-1:0]  quot;

    logic signed [gdd_pkg::ACC_W-1:0] add_a, add_b;
    logic        leap_calc, date_good, accept, out_free;
    logic [9:0]  ms_adj;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign cur_d = sel_reg ? d2_reg : d1_reg;
    assign cur_m = sel_reg ? m2_reg : m1_reg;
    assign cur_y = sel_reg ? y2_reg : y1_reg;
    assign cur_n = cur_y - gdd_pkg::YEAR_W'(1);

    assign quot = prod[gdd_pkg::RECIP_SHIFT +: gdd_pkg::QUOT_W];

    // century year when q*100 gives the year back; then leap needs q divisible by 4
    assign leap_calc = (cur_y[1:0] == 2'b00)
                    && ((prod != gdd_pkg::MUL_P_W'(cur_y)) || (qy_reg[1:0] == 2'b00));

    assign date_good = (cur_m inside {[4'd1:4'd12]})
                    && (cur_y >= gdd_pkg::YEAR_MIN) && (cur_y <= gdd_pkg::YEAR_MAX)
                    && (cur_d != '0)
                    && (cur_d <= gdd_pkg::month_len(cur_m, leap_calc));

    assign ms_adj = gdd_pkg::month_start(cur_m)
                  + 10'((cur_m > gdd_pkg::FEB) && leap_reg);

    gdd_mult u_mult
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    always_comb
    begin
        case (state_reg)
            gdd_pkg::ST_MUL_Q:
            begin
                mul_a = gdd_pkg::MUL_A_W'(quot);
                mul_b = gdd_pkg::CENTURY;
            end
            gdd_pkg::ST_LEAP:
            begin
                mul_a = cur_n;
                mul_b = gdd_pkg::RECIP_100;
            end
            gdd_pkg::ST_MUL_N:
            begin
                mul_a = cur_n;
                mul_b = gdd_pkg::DAYS_IN_YEAR;
            end
            default:
            begin
                mul_a = cur_y;
                mul_b = gdd_pkg::RECIP_100;
            end
        endcase
    end

    // operand select for the shared accumulator adder
    always_comb
    begin
        add_a = acc_reg;
        case (state_reg)
            gdd_pkg::ST_ACC_365:
            begin
                add_a = '0;
                add_b = $signed({1'b0, prod[gdd_pkg::COUNT_W-1:0]});
            end
            gdd_pkg::ST_ACC_N4: add_b = $signed(gdd_pkg::ACC_W'(cur_n[gdd_pkg::YEAR_W-1:2]));
            gdd_pkg::ST_ACC_QN: add_b = -$signed(gdd_pkg::ACC_W'(qn_reg));
            gdd_pkg::ST_ACC_Q4: add_b = $signed(gdd_pkg::ACC_W'(qn_reg[gdd_pkg::QUOT_W-1:2]));
            gdd_pkg::ST_ACC_MS: add_b = $signed(gdd_pkg::ACC_W'(ms_adj));
            gdd_pkg::ST_ACC_D:  add_b = $signed(gdd_pkg::ACC_W'(cur_d));
            gdd_pkg::ST_DIFF:   add_b = -$signed({1'b0, a_reg});
            gdd_pkg::ST_SIGN:
            begin
                // equal dates fall to the negative side
                if (acc_reg > 0)
                    add_b = $signed(gdd_pkg::ACC_W'(inc_reg));
                else
                    add_b = -$signed(gdd_pkg::ACC_W'(inc_reg));
            end
            default:   add_b = '0;
        endcase
        acc_next = add_a + add_b;
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        ok_next        = ok_reg;
        leap_next      = leap_reg;
        qy_next        = qy_reg;
        qn_next        = qn_reg;
        a_next         = a_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        bad_next       = bad_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            gdd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = gdd_pkg::ST_MUL_Y;
                    sel_next   = 1'b0;
                    ok_next    = 1'b1;
                end
            end
            gdd_pkg::ST_MUL_Y:   state_next = gdd_pkg::ST_MUL_Q;
            gdd_pkg::ST_MUL_Q:
            begin
                qy_next    = quot;
                state_next = gdd_pkg::ST_LEAP;
            end
            gdd_pkg::ST_LEAP:
            begin
                leap_next  = leap_calc;
                ok_next    = ok_reg && date_good;
                state_next = gdd_pkg::ST_MUL_N;
            end
            gdd_pkg::ST_MUL_N:
            begin
                qn_next    = quot;
                state_next = gdd_pkg::ST_ACC_365;
            end
            gdd_pkg::ST_ACC_365: state_next = gdd_pkg::ST_ACC_N4;
            gdd_pkg::ST_ACC_N4:  state_next = gdd_pkg::ST_ACC_QN;
            gdd_pkg::ST_ACC_QN:  state_next = gdd_pkg::ST_ACC_Q4;
            gdd_pkg::ST_ACC_Q4:  state_next = gdd_pkg::ST_ACC_MS;
            gdd_pkg::ST_ACC_MS:  state_next = gdd_pkg::ST_ACC_D;
            gdd_pkg::ST_ACC_D:
            begin
                if (!sel_reg)
                begin
                    a_next     = acc_next[gdd_pkg::COUNT_W-1:0];
                    sel_next   = 1'b1;
                    state_next = gdd_pkg::ST_MUL_Y;
                end
                else
                begin
                    state_next = gdd_pkg::ST_DIFF;
                end
            end
            gdd_pkg::ST_DIFF:    state_next = gdd_pkg::ST_SIGN;
            gdd_pkg::ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    count_next     = ok_reg ? acc_next[gdd_pkg::COUNT_W-1:0] : '0;
                    bad_next       = !ok_reg;
                    state_next     = gdd_pkg::ST_IDLE;
                end
            end
            default:    state_next = gdd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gdd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d1_reg  <= first_day;
            m1_reg  <= first_month;
            y1_reg  <= first_year;
            d2_reg  <= second_day;
            m2_reg  <= second_month;
            y2_reg  <= second_year;
            inc_reg <= count_end_day;
        end
        sel_reg   <= sel_next;
        ok_reg    <= ok_next;
        leap_reg  <= leap_next;
        qy_reg    <= qy_next;
        qn_reg    <= qn_next;
        a_reg     <= a_next;
        // the difference holds still while the sign step waits on the output
        if ((state_reg != gdd_pkg::ST_SIGN) || out_free)
            acc_reg <= acc_next;
        count_reg <= count_next;
        bad_reg   <= bad_next;
    end

    assign in_ready  = (state_reg == gdd_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign day_count = count_reg;
    assign bad_date  = bad_reg;

endmodule

// ===== design/gdd_checker.sv =====
`timescale 1ns / 1ps

module gdd_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [gdd_pkg::COUNT_W-1:0]  day_count,
    input  logic                                bad_date
);

    // a waiting result holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(day_count) && $stable(bad_date))
        else $error("result changed while stalled");

    // an invalid date always reports a zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_date |-> day_count == '0)
        else $error("bad date with non-zero count");

    // one item at a time: busy straight after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // a result does not appear straight after acceptance if none was waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

endmodule

bind gregorian_date_difference_top gdd_checker u_gdd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .day_count (day_count),
    .bad_date  (bad_date)
);

// ===== verif/tb_gregorian_date_difference_top.sv =====
`timescale 1ns / 1ps

module tb_gregorian_date_difference_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_ITEMS   = 1880;

    typedef struct {
        logic [gdd_pkg::DAY_W-1:0]   first_day;
        logic [gdd_pkg::MONTH_W-1:0] first_month;
        logic [gdd_pkg::YEAR_W-1:0]  first_year;
        logic [gdd_pkg::DAY_W-1:0]   second_day;
        logic [gdd_pkg::MONTH_W-1:0] second_month;
        logic [gdd_pkg::YEAR_W-1:0]  second_year;
        logic                        count_end_day;
    } date_pair_t;

    typedef struct {
        logic signed [gdd_pkg::COUNT_W-1:0] day_count;
        logic                               bad_date;
    } day_gap_t;

    typedef enum int {
        Q_SPREAD,
        Q_NEAR,
        Q_SAME,
        Q_BROKEN,
        Q_NOISE
    } query_kind_t;

    class day_gap_board;
        day_gap_t    expected_gaps[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function bit leap(int unsigned y);
            return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
        endfunction

        static function int unsigned month_days(int unsigned m, int unsigned y);
            case (m)
                2:          return leap(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:    return 31;
            endcase
        endfunction

        static function bit date_ok(int unsigned d, int unsigned m, int unsigned y);
            if (m < 1 || m > 12 || y < 1 || y > 9999 || d < 1)
                return 1'b0;
            return d <= month_days(m, y);
        endfunction

        // days since a fixed epoch; only meaningful for valid dates
        static function int unsigned ordinal_day(int unsigned d, int unsigned m,
                                                 int unsigned y);
            int unsigned n;
            int unsigned v;
            n = y - 1;
            v = 365 * n + n / 4 - n / 100 + n / 400;
            for (int unsigned k = 1; k < m; k++)
                v += month_days(k, y);
            return v + d;
        endfunction

        function day_gap_t predict_gap(date_pair_t q);
            day_gap_t    r;
            int unsigned a;
            int unsigned b;
            int          mag;
            r.day_count = '0;
            r.bad_date  = 1'b0;
            if (!date_ok(32'(q.first_day), 32'(q.first_month), 32'(q.first_year)) ||
                !date_ok(32'(q.second_day), 32'(q.second_month), 32'(q.second_year)))
            begin
                r.bad_date = 1'b1;
                return r;
            end
            a = ordinal_day(32'(q.first_day), 32'(q.first_month), 32'(q.first_year));
            b = ordinal_day(32'(q.second_day), 32'(q.second_month), 32'(q.second_year));
            // equal dates count as "not earlier", hence the negative sign
            if (a < b)
            begin
                mag = int'(b - a) + int'(q.count_end_day);
                r.day_count = gdd_pkg::COUNT_W'(mag);
            end
            else
            begin
                mag = int'(a - b) + int'(q.count_end_day);
                r.day_count = gdd_pkg::COUNT_W'(-mag);
            end
            return r;
        endfunction

        function void note_item(date_pair_t q);
            expected_gaps.push_back(predict_gap(q));
        endfunction

        function void check_result(logic signed [gdd_pkg::COUNT_W-1:0] cnt, logic bad);
            day_gap_t want;
            if (expected_gaps.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected item, expected none, got day_count %0d bad_date %0b",
                         $time, cnt, bad);
                return;
            end
            want = expected_gaps.pop_front();
            if (cnt !== want.day_count)
            begin
                mismatches++;
                $display("%0t: day_count expected %0d got %0d",
                         $time, want.day_count, cnt);
            end
            if (bad !== want.bad_date)
            begin
                mismatches++;
                $display("%0t: bad_date expected %0b got %0b",
                         $time, want.bad_date, bad);
            end
        endfunction

        function int pending();
            return expected_gaps.size();
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [gdd_pkg::DAY_W-1:0]          first_day = '0;
    logic [gdd_pkg::MONTH_W-1:0]        first_month = '0;
    logic [gdd_pkg::YEAR_W-1:0]         first_year = '0;
    logic [gdd_pkg::DAY_W-1:0]          second_day = '0;
    logic [gdd_pkg::MONTH_W-1:0]        second_month = '0;
    logic [gdd_pkg::YEAR_W-1:0]         second_year = '0;
    logic                               count_end_day = 1'b0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic signed [gdd_pkg::COUNT_W-1:0] day_count;
    logic                               bad_date;

    day_gap_board board = new();
    int unsigned  send_gap_max = 12;
    int unsigned  take_gap_max = 12;
    bit           long_hold_req = 1'b0;
    int unsigned  idle_cycles = 0;

    gregorian_date_difference_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .first_day     (first_day),
        .first_month   (first_month),
        .first_year    (first_year),
        .second_day    (second_day),
        .second_month  (second_month),
        .second_year   (second_year),
        .count_end_day (count_end_day),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .day_count     (day_count),
        .bad_date      (bad_date)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // handshakes are sampled at the edge, before any of its updates land
    always @(posedge clk)
    begin : watch_channels
        date_pair_t q;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                q.first_day     = first_day;
                q.first_month   = first_month;
                q.first_year    = first_year;
                q.second_day    = second_day;
                q.second_month  = second_month;
                q.second_year   = second_year;
                q.count_end_day = count_end_day;
                board.note_item(q);
            end
            if (out_valid && out_ready)
                board.check_result(day_count, bad_date);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin : result_taker
        int unsigned hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            else
                hold = $urandom_range(0, take_gap_max);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // called at a rising edge; returns at the edge that accepts the item
    task automatic send_item(input date_pair_t q);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        first_day     <= q.first_day;
        first_month   <= q.first_month;
        first_year    <= q.first_year;
        second_day    <= q.second_day;
        second_month  <= q.second_month;
        second_year   <= q.second_year;
        count_end_day <= q.count_end_day;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    task automatic send_dates(input int d1, input int m1, input int y1,
                              input int d2, input int m2, input int y2, input bit inc);
        date_pair_t q;
        q.first_day     = gdd_pkg::DAY_W'(d1);
        q.first_month   = gdd_pkg::MONTH_W'(m1);
        q.first_year    = gdd_pkg::YEAR_W'(y1);
        q.second_day    = gdd_pkg::DAY_W'(d2);
        q.second_month  = gdd_pkg::MONTH_W'(m2);
        q.second_year   = gdd_pkg::YEAR_W'(y2);
        q.count_end_day = inc;
        send_item(q);
    endtask

    function automatic void pick_date(output logic [gdd_pkg::DAY_W-1:0] d,
                                      output logic [gdd_pkg::MONTH_W-1:0] m,
                                      output logic [gdd_pkg::YEAR_W-1:0] y);
        int unsigned yy;
        int unsigned mm;
        int unsigned len;
        case ($urandom_range(0, 9))
            0:       yy = $urandom_range(1, 4);
            1:       yy = $urandom_range(9996, 9999);
            2:       yy = 100 * $urandom_range(1, 99);
            3:       yy = $urandom_range(8190, 8194);
            default: yy = $urandom_range(1, 9999);
        endcase
        mm  = $urandom_range(1, 12);
        len = day_gap_board::month_days(mm, yy);
        d   = gdd_pkg::DAY_W'(($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len));
        m   = gdd_pkg::MONTH_W'(mm);
        y   = gdd_pkg::YEAR_W'(yy);
    endfunction

    // spoils one field of an otherwise good date, or makes it a Feb 29-31 of an odd year
    function automatic void spoil_date(inout logic [gdd_pkg::DAY_W-1:0] d,
                                       inout logic [gdd_pkg::MONTH_W-1:0] m,
                                       inout logic [gdd_pkg::YEAR_W-1:0] y);
        int unsigned len;
        len = day_gap_board::month_days(32'(m), 32'(y));
        case ($urandom_range(0, 4))
            0: d = '0;
            1: m = gdd_pkg::MONTH_W'($urandom_range(0, 1) ? 0 : $urandom_range(13, 15));
            2: y = gdd_pkg::YEAR_W'($urandom_range(0, 1) ? 0 : $urandom_range(10000, 16383));
            3: d = gdd_pkg::DAY_W'((len < 31) ? $urandom_range(len + 1, 31) : 0);
            default:
            begin
                m = gdd_pkg::FEB;
                y = gdd_pkg::YEAR_W'(2 * $urandom_range(0, 4999) + 1);
                d = gdd_pkg::DAY_W'($urandom_range(29, 31));
            end
        endcase
    endfunction

    function automatic date_pair_t make_query(query_kind_t kind);
        date_pair_t q;
        int         yy;
        pick_date(q.first_day, q.first_month, q.first_year);
        pick_date(q.second_day, q.second_month, q.second_year);
        q.count_end_day = 1'($urandom_range(0, 1));
        case (kind)
            Q_NEAR:
            begin
                yy = int'(q.first_year) + $urandom_range(0, 2) - 1;
                if (yy < 1)
                    yy = 1;
                if (yy > 9999)
                    yy = 9999;
                q.second_year  = gdd_pkg::YEAR_W'(yy);
                q.second_month = $urandom_range(0, 1) ? q.first_month : q.second_month;
                q.second_day   = gdd_pkg::DAY_W'($urandom_range(1,
                    day_gap_board::month_days(32'(q.second_month), 32'(q.second_year))));
            end
            Q_SAME:
            begin
                q.second_day   = q.first_day;
                q.second_month = q.first_month;
                q.second_year  = q.first_year;
            end
            Q_BROKEN:
            begin
                if ($urandom_range(0, 1))
                    spoil_date(q.first_day, q.first_month, q.first_year);
                else
                    spoil_date(q.second_day, q.second_month, q.second_year);
            end
            Q_NOISE:
            begin
                q.first_day    = gdd_pkg::DAY_W'($urandom);
                q.first_month  = gdd_pkg::MONTH_W'($urandom);
                q.first_year   = gdd_pkg::YEAR_W'($urandom);
                q.second_day   = gdd_pkg::DAY_W'($urandom);
                q.second_month = gdd_pkg::MONTH_W'($urandom);
                q.second_year  = gdd_pkg::YEAR_W'($urandom);
            end
            default: ;
        endcase
        return q;
    endfunction

    initial
    begin : stimulus
        int unsigned pick;
        int unsigned phase;
        query_kind_t kind;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_dates(1, 1, 1, 1, 1, 1, 0);
        send_dates(1, 1, 1, 1, 1, 1, 1);
        send_dates(1, 1, 1, 31, 12, 9999, 0);
        send_dates(1, 1, 1, 31, 12, 9999, 1);
        send_dates(31, 12, 9999, 1, 1, 1, 1);
        send_dates(31, 12, 9999, 1, 1, 1, 0);
        send_dates(28, 2, 1900, 1, 3, 1900, 0);
        send_dates(29, 2, 2000, 1, 3, 2000, 1);
        send_dates(29, 2, 1900, 1, 1, 2000, 0);
        send_dates(29, 2, 2004, 29, 2, 2004, 1);
        send_dates(1, 1, 2001, 29, 2, 2001, 0);
        send_dates(0, 5, 2020, 1, 5, 2020, 0);
        send_dates(1, 5, 2021, 31, 4, 2021, 1);
        send_dates(10, 0, 2020, 10, 1, 2020, 0);
        send_dates(10, 1, 2020, 10, 13, 2020, 0);
        send_dates(31, 15, 16383, 31, 15, 16383, 1);
        send_dates(5, 6, 0, 5, 6, 1, 0);
        send_dates(5, 6, 9999, 5, 6, 10000, 1);
        send_dates(31, 12, 1999, 1, 1, 2000, 0);
        send_dates(1, 1, 2000, 31, 12, 1999, 0);
        send_dates(15, 8, 8191, 16, 8, 8192, 1);
        send_dates(31, 1, 2023, 28, 2, 2023, 0);
        send_dates(31, 12, 2400, 1, 3, 2400, 1);
        wait_for_drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            phase        = i / 250;
            send_gap_max = (phase % 2) ? 0 : 12;
            take_gap_max = (phase % 3 == 1) ? 0 : 12;
            // receiver stalls while the sender keeps pushing at full rate
            if (i == 300 || i == 1300)
            begin
                send_gap_max  = 0;
                long_hold_req = 1'b1;
            end
            if (i == 900 || i == 1600)
                wait_for_drain();
            pick = $urandom_range(0, 99);
            if (pick < 40)
                kind = Q_SPREAD;
            else if (pick < 65)
                kind = Q_NEAR;
            else if (pick < 73)
                kind = Q_SAME;
            else if (pick < 90)
                kind = Q_BROKEN;
            else
                kind = Q_NOISE;
            send_item(make_query(kind));
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
